>>> rtl/dtt_pkg.sv
// Shared widths, codes, state type and saturating add for the deadline timer table.
package dtt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int CMD_W           = 2;
    localparam int TIME_W          = 48;
    localparam int DELAY_W         = 32;
    localparam int OWNER_W         = 8;
    localparam int KIND_W          = 3;
    localparam int SLOT_W          = 4;
    localparam int ENTRY_W         = TIME_W + DELAY_W + OWNER_W;

    localparam logic [DELAY_W-1:0] HORIZON_RESET   = 32'd1800000000;
    localparam logic [DELAY_W-1:0] MIN_SLEEP_DELAY = 32'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PERIODIC = 2'd0,
        CMD_SLEEP    = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATED  = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_PERIODIC = 3'd2,
        KIND_WOKEN    = 3'd3,
        KIND_NEXT     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CSCAN,
        ST_TSTART,
        ST_TSCAN,
        ST_TEND
    } state_t;

    // Add a 32-bit offset to a 48-bit time, clamp at all ones.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [DELAY_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {{(TIME_W + 1 - DELAY_W){1'b0}}, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

>>> rtl/dtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/deadline_timer_table.sv
// Top level of the deadline timer table: command sequencer, slot state and result register.
//
// Create: scans from slot 0 for the lowest free slot and fills it; a full table is reported
// after the last slot. One result, shown the cycle after the last busy cycle.
// Tick: forms now+horizon, passes every slot through the shared adder and the entry RAM
// port, then gives the next-deadline result.
// Reset clears valid bits and control and loads the horizon with HORIZON_RESET at once; the entry RAM is never cleared.
// Results carry a one-cycle strobe; the receiver cannot stall them.
module deadline_timer_table #(
    parameter int TIMER_SLOTS = dtt_pkg::TIMER_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic [dtt_pkg::CMD_W-1:0]     command,
    input  logic [dtt_pkg::TIME_W-1:0]    now,
    input  logic [dtt_pkg::DELAY_W-1:0]   delay,
    input  logic [dtt_pkg::DELAY_W-1:0]   interval,
    input  logic [dtt_pkg::OWNER_W-1:0]   owner,
    // horizon register write
    input  logic                          horizon_we,
    input  logic [dtt_pkg::DELAY_W-1:0]   horizon_wdata,
    // results
    output logic                          strobe,
    output logic [dtt_pkg::KIND_W-1:0]    kind,
    output logic [dtt_pkg::SLOT_W-1:0]    slot,
    output logic [dtt_pkg::OWNER_W-1:0]   owner_out,
    output logic [dtt_pkg::TIME_W-1:0]    deadline,
    output logic                          last
);

    import dtt_pkg::*;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_SLOTS - 1);

    // Sequencer and control state
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [TIMER_SLOTS-1:0] periodic_reg, periodic_next;
    logic [DELAY_W-1:0]     horizon_reg;
    logic                   strobe_reg, strobe_next;

    // Captured request and scan accumulators
    logic                   pcmd_reg, pcmd_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [DELAY_W-1:0]     delay_reg, delay_next;
    logic [DELAY_W-1:0]     interval_reg, interval_next;
    logic [OWNER_W-1:0]     owner_reg, owner_next;
    logic [TIME_W-1:0]      next_reg, next_dl_next;

    // Result register
    kind_t                  kind_reg, kind_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [OWNER_W-1:0]     owner_out_reg, owner_out_next;
    logic [TIME_W-1:0]      deadline_reg, deadline_next;
    logic                   last_reg, last_next;

    // Entry RAM: {deadline, interval, owner}
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
    logic [TIME_W-1:0]      rd_deadline;
    logic [DELAY_W-1:0]     rd_interval;
    logic [OWNER_W-1:0]     rd_owner;

    // Shared saturating adder
    logic [TIME_W-1:0]      add_a, add_sum;
    logic [DELAY_W-1:0]     add_b;

    logic                   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign {rd_deadline, rd_interval, rd_owner} = ram_rdata;
    assign add_sum = sat_add(add_a, add_b);

    dtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_PERIODIC, CMD_SLEEP: state_next = ST_CSCAN;
                        CMD_TICK:                state_next = ST_TSTART;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CSCAN:
            begin
                if (!valid_reg[idx_reg] || idx_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TSTART:
            begin
                state_next = ST_TSCAN;
            end
            ST_TSCAN:
            begin
                if (idx_reg == IDX_LAST)
                begin
                    state_next = ST_TEND;
                end
            end
            ST_TEND:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and results
    always_comb
    begin
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        periodic_next  = periodic_reg;
        pcmd_next      = pcmd_reg;
        now_next       = now_reg;
        delay_next     = delay_reg;
        interval_next  = interval_reg;
        owner_next     = owner_reg;
        next_dl_next   = next_reg;
        strobe_next    = 1'b0;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        owner_out_next = owner_out_reg;
        deadline_next  = deadline_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_wdata      = {rd_deadline, rd_interval, rd_owner};
        ram_raddr      = idx_reg + IDX_W'(1);
        add_a          = now_reg;
        add_b          = delay_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Capture the request; raise a zero sleep delay, drop the
                    // interval of a sleeper.
                    idx_next      = '0;
                    pcmd_next     = (command == CMD_PERIODIC);
                    now_next      = now;
                    owner_next    = owner;
                    delay_next    = delay;
                    interval_next = interval;
                    if (command != CMD_PERIODIC)
                    begin
                        interval_next = '0;
                        if (delay < MIN_SLEEP_DELAY)
                        begin
                            delay_next = MIN_SLEEP_DELAY;
                        end
                    end
                end
            end
            ST_CSCAN:
            begin
                add_a = now_reg;
                add_b = delay_reg;
                if (!valid_reg[idx_reg])
                begin
                    ram_we                 = 1'b1;
                    ram_wdata              = {add_sum, interval_reg, owner_reg};
                    valid_next[idx_reg]    = 1'b1;
                    periodic_next[idx_reg] = pcmd_reg;
                    strobe_next            = 1'b1;
                    kind_next              = KIND_CREATED;
                    slot_next              = SLOT_W'(idx_reg);
                    owner_out_next         = owner_reg;
                    deadline_next          = add_sum;
                    last_next              = 1'b1;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    strobe_next    = 1'b1;
                    kind_next      = KIND_FULL;
                    slot_next      = '0;
                    owner_out_next = owner_reg;
                    deadline_next  = '0;
                    last_next      = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_TSTART:
            begin
                // Form the capped next deadline and prime the read of slot 0.
                add_a        = now_reg;
                add_b        = horizon_reg;
                next_dl_next = add_sum;
                ram_raddr    = '0;
            end
            ST_TSCAN:
            begin
                // Read data belongs to idx_reg; the next slot is being read.
                add_a = rd_deadline;
                add_b = rd_interval;
                if (valid_reg[idx_reg])
                begin
                    if (rd_deadline < now_reg)
                    begin
                        strobe_next    = 1'b1;
                        slot_next      = SLOT_W'(idx_reg);
                        owner_out_next = rd_owner;
                        last_next      = 1'b0;
                        if (periodic_reg[idx_reg])
                        begin
                            ram_we        = 1'b1;
                            ram_wdata     = {add_sum, rd_interval, rd_owner};
                            kind_next     = KIND_PERIODIC;
                            deadline_next = add_sum;
                        end
                        else
                        begin
                            valid_next[idx_reg] = 1'b0;
                            kind_next           = KIND_WOKEN;
                            deadline_next       = rd_deadline;
                        end
                    end
                    else if (rd_deadline < next_reg)
                    begin
                        next_dl_next = rd_deadline;
                    end
                end
                if (idx_reg != IDX_LAST)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_TEND:
            begin
                strobe_next    = 1'b1;
                kind_next      = KIND_NEXT;
                slot_next      = '0;
                owner_out_next = '0;
                deadline_next  = next_reg;
                last_next      = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            valid_reg    <= '0;
            periodic_reg <= '0;
            horizon_reg  <= HORIZON_RESET;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
            periodic_reg <= periodic_next;
            strobe_reg   <= strobe_next;
            if (horizon_we)
            begin
                horizon_reg <= horizon_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pcmd_reg      <= pcmd_next;
        now_reg       <= now_next;
        delay_reg     <= delay_next;
        interval_reg  <= interval_next;
        owner_reg     <= owner_next;
        next_reg      <= next_dl_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        owner_out_reg <= owner_out_next;
        deadline_reg  <= deadline_next;
        last_reg      <= last_next;
    end

    assign strobe    = strobe_reg;
    assign kind      = kind_reg;
    assign slot      = slot_reg;
    assign owner_out = owner_out_reg;
    assign deadline  = deadline_reg;
    assign last      = last_reg;

    // A create or table-full result always closes its request
    a_create_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_CREATED || kind == KIND_FULL) |-> last)
        else $error("create result without last");

    // Only the next-deadline result closes a tick
    a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_PERIODIC || kind == KIND_WOKEN) |-> !last)
        else $error("firing result marked last");

    // An accepted tick keeps the block busy
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == CMD_TICK |=> busy ##1 busy)
        else $error("tick did not hold busy");

    // A result appears only after the sequencer has worked
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg) != ST_IDLE && $past(state_reg) != ST_TSTART)
        else $error("result without a producing state");

endmodule
